>>> rtl/dhcp_scan_pkg.sv
// Types and codes shared by the DHCP option scanner.
// No dependencies; imported by dhcp_option_tlv_scanner_core.
`default_nettype none
package dhcp_scan_pkg;

  localparam logic [7:0] BYTE_PAD = 8'd0;
  localparam logic [7:0] BYTE_END = 8'd255;

  localparam logic [7:0] WANTED_CODE_RST  = 8'd53;
  localparam logic [7:0] MAX_COPY_LEN_RST = 8'd4;

  typedef enum logic {
    CFG_WANTED_CODE  = 1'b0,
    CFG_MAX_COPY_LEN = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_CODE      = 3'd0,
    PH_SKIP_LEN  = 3'd1,
    PH_SKIP_DATA = 3'd2,
    PH_MATCH_LEN = 3'd3,
    PH_COPY      = 3'd4,
    PH_DONE      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_VALUE     = 2'd0,
    ST_MATCH     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_TRUNC     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       area_start;
    logic       area_end;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] value_byte;
    logic [7:0] value_index;
    logic [7:0] option_length;
    logic       last;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/dhcp_option_tlv_scanner_core.sv
// DHCP option scanner: searches an options byte stream for one option code.
// Timing: results are registered; a result is valid in the cycle after the item that causes it is accepted.
// Throughput: one item per cycle while the output is not stalled, set by the single output register.
// Reset: synchronous, active low; config returns to code 53, copy length 4,
// and the scan waits for an option code.
// Depends on dhcp_scan_pkg.
`default_nettype none
module dhcp_option_tlv_scanner_core (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  dhcp_scan_pkg::in_item_t    in_item,
  output logic                       out_valid,
  input  wire                        out_stall,
  output dhcp_scan_pkg::out_item_t   out_item,
  input  wire                        cfg_we,
  input  wire                        cfg_index,
  input  wire  [7:0]                 cfg_wdata
);
  import dhcp_scan_pkg::*;

  logic [7:0] wanted_code_r;
  logic [7:0] max_copy_len_r;

  phase_t     phase_r, phase_nxt;
  phase_t     phase_step;
  logic [7:0] skip_rem_r, skip_rem_nxt;
  logic [7:0] copy_rem_r, copy_rem_nxt;
  logic [7:0] copy_pos_r, copy_pos_nxt;

  logic       out_valid_r;
  out_item_t  out_item_r;

  logic       in_acc;
  logic       res_valid;
  out_item_t  res;

  phase_t     ph_cur;
  logic [7:0] skip_cur, copy_cur, pos_cur;
  logic [7:0] b;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign b         = in_item.option_byte;

  always_comb begin
    ph_cur   = in_item.area_start ? PH_CODE : phase_r;
    skip_cur = in_item.area_start ? 8'd0 : skip_rem_r;
    copy_cur = in_item.area_start ? 8'd0 : copy_rem_r;
    pos_cur  = in_item.area_start ? 8'd0 : copy_pos_r;
  end

  // next state
  always_comb begin
    phase_step   = ph_cur;
    skip_rem_nxt = skip_cur;
    copy_rem_nxt = copy_cur;
    copy_pos_nxt = pos_cur;
    unique case (ph_cur)
      PH_CODE: begin
        priority if (b == BYTE_PAD) begin
          phase_step = PH_CODE;
        end else if (b == BYTE_END) begin
          phase_step = PH_DONE;
        end else if (b == wanted_code_r) begin
          phase_step = PH_MATCH_LEN;
        end else begin
          phase_step = PH_SKIP_LEN;
        end
      end
      PH_SKIP_LEN: begin
        skip_rem_nxt = b;
        phase_step   = (b == 8'd0) ? PH_CODE : PH_SKIP_DATA;
      end
      PH_SKIP_DATA: begin
        skip_rem_nxt = skip_cur - 8'd1;
        if (skip_cur == 8'd1) begin
          phase_step = PH_CODE;
        end
      end
      PH_MATCH_LEN: begin
        copy_rem_nxt = (b < max_copy_len_r) ? b : max_copy_len_r;
        copy_pos_nxt = 8'd0;
        phase_step   = (copy_rem_nxt == 8'd0) ? PH_DONE : PH_COPY;
      end
      PH_COPY: begin
        copy_rem_nxt = copy_cur - 8'd1;
        copy_pos_nxt = pos_cur + 8'd1;
        if (copy_cur == 8'd1) begin
          phase_step = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_step = PH_DONE;
      end
      default: begin
        phase_step = PH_DONE;
      end
    endcase
    phase_nxt = phase_step;
    if (in_item.area_end && ph_cur != PH_DONE) begin
      phase_nxt = PH_DONE;
    end
  end

  // result
  always_comb begin
    res_valid         = 1'b0;
    res.status        = ST_VALUE;
    res.value_byte    = 8'd0;
    res.value_index   = 8'd0;
    res.option_length = 8'd0;
    res.last          = 1'b0;
    unique case (ph_cur)
      PH_CODE: begin
        if (b == BYTE_END) begin
          res_valid  = 1'b1;
          res.status = ST_NOT_FOUND;
          res.last   = 1'b1;
        end
      end
      PH_MATCH_LEN: begin
        res_valid         = 1'b1;
        res.status        = ST_MATCH;
        res.option_length = b;
        res.last          = (b == 8'd0) || (max_copy_len_r == 8'd0);
      end
      PH_COPY: begin
        res_valid       = 1'b1;
        res.status      = ST_VALUE;
        res.value_byte  = b;
        res.value_index = pos_cur;
        res.last        = (copy_cur == 8'd1);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    if (in_item.area_end && ph_cur != PH_DONE && phase_step != PH_DONE) begin
      res_valid         = 1'b1;
      res.status        = ST_TRUNC;
      res.value_byte    = 8'd0;
      res.value_index   = 8'd0;
      res.option_length = 8'd0;
      res.last          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_code_r  <= WANTED_CODE_RST;
      max_copy_len_r <= MAX_COPY_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_WANTED_CODE:  wanted_code_r  <= cfg_wdata;
        CFG_MAX_COPY_LEN: max_copy_len_r <= cfg_wdata;
        default:          wanted_code_r  <= wanted_code_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CODE;
      skip_rem_r <= 8'd0;
      copy_rem_r <= 8'd0;
      copy_pos_r <= 8'd0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      skip_rem_r <= skip_rem_nxt;
      copy_rem_r <= copy_rem_nxt;
      copy_pos_r <= copy_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_item_r <= res;
    end
  end

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_DONE && !in_item.area_start) |=> !out_valid_r)
    else $error("result produced after search finished");

  a_match_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_valid && res.status == ST_MATCH && !res.last)
      |=> phase_r == PH_COPY)
    else $error("match without copy phase");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_valid && res.last) |=> phase_r == PH_DONE)
    else $error("final result did not finish the search");

  a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COPY) |-> (copy_rem_r != 8'd0))
    else $error("copy phase with nothing left to copy");

endmodule
`default_nettype wire
